// File: src/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants of the frustum cull test
// Field widths, command codes, plane packing and the item record that
// travels along the chain of plane cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

  // number of frustum planes, one cell each
  localparam int NumPlanes = 6;
  localparam int PlaneIdxW = $clog2(NumPlanes);

  // field widths
  localparam int CmdW    = 2;
  localparam int CoordW  = 24;
  localparam int RadiusW = 23;
  localparam int PlaneW  = 64;
  localparam int CoefW   = 12;
  localparam int DistOffW = 28;

  // plane packing: a, b, c, d
  localparam int ALo = 0;
  localparam int BLo = 12;
  localparam int CLo = 24;
  localparam int DLo = 36;

  // d and radius are scaled by 2^10 to line up with the products
  localparam int AlignShift = 10;
  localparam int ProdW = CoefW + CoordW;   // 36
  localparam int SumW  = ProdW + 4;        // 40, holds dist plus radius

  // command codes
  localparam logic [CmdW-1:0] CmdPoint  = 2'd0;
  localparam logic [CmdW-1:0] CmdSphere = 2'd1;
  localparam logic [CmdW-1:0] CmdBox    = 2'd2;

  // one item with its running verdict
  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic [RadiusW-1:0]       radius;
    logic                     visible;
  } item_t;

endpackage : fct_pkg

`default_nettype wire

// File: src/fct_in_if.sv
// ----------------------------------------------------------------------------
// fct_in_if: input channel of the frustum cull test
// Valid/ready channel carrying one primitive to test.
// ----------------------------------------------------------------------------
`default_nettype none

interface fct_in_if;
  import fct_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          command;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;
  logic signed [CoordW-1:0] max_x;
  logic signed [CoordW-1:0] max_y;
  logic signed [CoordW-1:0] max_z;
  logic [RadiusW-1:0]       radius;

  modport source (
    output valid, command, pos_x, pos_y, pos_z, max_x, max_y, max_z, radius,
    input  ready
  );

  modport sink (
    input  valid, command, pos_x, pos_y, pos_z, max_x, max_y, max_z, radius,
    output ready
  );

endinterface : fct_in_if

`default_nettype wire

// File: src/fct_out_if.sv
// ----------------------------------------------------------------------------
// fct_out_if: result channel of the frustum cull test
// Valid/ready channel carrying the inside/outside verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface fct_out_if;

  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);

endinterface : fct_out_if

`default_nettype wire

// File: src/frustum_cull_test_top.sv
// ----------------------------------------------------------------------------
// frustum_cull_test_top: point, sphere and box test against six planes
// Pipeline: 12 register stages (two per plane cell, six cells in a row).
// Throughput: one item per cycle; each stage holds one item and moves on
//   as soon as the next stage has room, so items stream back to back.
// Reset: all planes clear to zero (every primitive reads inside), the
//   pipeline empties; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_test_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration writes
  input  wire                          cfg_we_i,
  input  wire  [fct_pkg::PlaneIdxW-1:0] cfg_idx_i,
  input  wire  [fct_pkg::PlaneW-1:0]   cfg_data_i,
  // channels
  fct_in_if.sink                       in_i,
  fct_out_if.source                    out_o
);
  import fct_pkg::*;

  logic  [NumPlanes:0] node_valid;
  logic  [NumPlanes:0] node_ready;
  item_t               node_item [NumPlanes+1];

  // input item enters with an inside verdict
  assign node_item[0] = '{command: in_i.command,
                          pos_x:   in_i.pos_x,
                          pos_y:   in_i.pos_y,
                          pos_z:   in_i.pos_z,
                          max_x:   in_i.max_x,
                          max_y:   in_i.max_y,
                          max_z:   in_i.max_z,
                          radius:  in_i.radius,
                          visible: 1'b1};

  assign node_valid[0] = in_i.valid;
  assign in_i.ready    = node_ready[0];

  // chain of plane cells
  for (genvar k = 0; k < NumPlanes; k++) begin : g_cell
    fct_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_we_i   (cfg_we_i && (cfg_idx_i == PlaneIdxW'(k))),
      .cfg_data_i (cfg_data_i),
      .valid_i    (node_valid[k]),
      .ready_o    (node_ready[k]),
      .item_i     (node_item[k]),
      .valid_o    (node_valid[k+1]),
      .ready_i    (node_ready[k+1]),
      .item_o     (node_item[k+1])
    );
  end

  // result channel
  assign out_o.valid          = node_valid[NumPlanes];
  assign node_ready[NumPlanes] = out_o.ready;
  assign out_o.inside_res     = node_item[NumPlanes].visible;

endmodule : frustum_cull_test_top

`default_nettype wire

// File: src/fct_cell.sv
// ----------------------------------------------------------------------------
// fct_cell: one plane of the frustum test
// Holds one plane register. Stage A picks the p-vertex and forms the three
// products, stage B sums them with d (and the radius for a sphere) and
// clears the inside flag of a point, sphere or box on a negative result.
// Items move on to the next cell; each stage collapses bubbles on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_cell (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // plane register write
  input  wire                         cfg_we_i,
  input  wire  [fct_pkg::PlaneW-1:0]  cfg_data_i,
  // from previous cell
  input  wire                         valid_i,
  output logic                        ready_o,
  input  wire  fct_pkg::item_t        item_i,
  // to next cell
  output logic                        valid_o,
  input  wire                         ready_i,
  output fct_pkg::item_t              item_o
);
  import fct_pkg::*;

  logic [PlaneW-1:0] plane_q;

  logic signed [CoefW-1:0]    coef_a, coef_b, coef_c;
  logic signed [DistOffW-1:0] coef_d;
  logic                       is_box;
  logic signed [CoordW-1:0]   sel_x, sel_y, sel_z;

  logic              va_q, vb_q;
  logic              adv_a, adv_b;
  item_t             a_q, b_q;
  item_t             b_d;
  logic signed [ProdW-1:0] pa_q, pb_q, pc_q;
  logic signed [ProdW-1:0] pa_d, pb_d, pc_d;
  logic signed [SumW-1:0]  sum;
  logic                    tested;

  // plane register, zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_we_i) begin
      plane_q <= cfg_data_i;
    end
  end

  assign coef_a = plane_q[ALo +: CoefW];
  assign coef_b = plane_q[BLo +: CoefW];
  assign coef_c = plane_q[CLo +: CoefW];
  assign coef_d = plane_q[DLo +: DistOffW];

  // handshake: each stage moves when its successor has room
  assign adv_b   = !vb_q || ready_i;
  assign adv_a   = !va_q || adv_b;
  assign ready_o = adv_a;
  assign valid_o = vb_q;
  assign item_o  = b_q;

  // stage A: p-vertex select and products
  always_comb begin
    is_box = (item_i.command == CmdBox);
    sel_x  = (is_box && (coef_a > 0)) ? item_i.max_x : item_i.pos_x;
    sel_y  = (is_box && (coef_b > 0)) ? item_i.max_y : item_i.pos_y;
    sel_z  = (is_box && (coef_c > 0)) ? item_i.max_z : item_i.pos_z;
    pa_d   = ProdW'(coef_a * sel_x);
    pb_d   = ProdW'(coef_b * sel_y);
    pc_d   = ProdW'(coef_c * sel_z);
  end

  // stage B: distance plus radius, sign check (d is sign extended)
  always_comb begin
    tested = (a_q.command == CmdPoint) || (a_q.command == CmdSphere) ||
             (a_q.command == CmdBox);
    sum = SumW'(pa_q) + SumW'(pb_q) + SumW'(pc_q) +
          SumW'($signed({coef_d, {AlignShift{1'b0}}}));
    if (a_q.command == CmdSphere) begin
      sum = sum + SumW'({1'b0, a_q.radius, {AlignShift{1'b0}}});
    end
    b_d         = a_q;
    b_d.visible = a_q.visible && !(tested && sum[SumW-1]);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= valid_i;
      if (adv_b) vb_q <= va_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv_a && valid_i) begin
      a_q  <= item_i;
      pa_q <= pa_d;
      pb_q <= pb_d;
      pc_q <= pc_d;
    end
    if (adv_b && va_q) begin
      b_q <= b_d;
    end
  end

`ifndef ASSERT_OFF
  // a stalled result is never dropped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !ready_i |=> vb_q)
    else $error("fct_cell: stalled item lost");

  // an item already culled stays culled through stage A
  a_culled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && !item_i.visible |=> va_q && !a_q.visible)
    else $error("fct_cell: culled verdict revived");

  // stage B only fills from a valid stage A
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !va_q && adv_b |=> !vb_q)
    else $error("fct_cell: stage B filled from empty stage A");

  // plane write takes effect on the next cycle
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> plane_q == $past(cfg_data_i))
    else $error("fct_cell: plane write not taken");
`endif

endmodule : fct_cell

`default_nettype wire

// File: test/fct_cull_checker.sv
// ----------------------------------------------------------------------------
// fct_cull_checker: verdict predictor and result checker for the cull test
// Watches the configuration port and both channels. Keeps its own copy of
// the six planes, predicts the inside verdict of every primitive at its input
// transfer and compares it with the verdict at the matching result transfer.
// ----------------------------------------------------------------------------
module fct_cull_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fct_pkg::PlaneIdxW-1:0] cfg_idx_i,
  input  logic [fct_pkg::PlaneW-1:0]    cfg_data_i,
  fct_in_if                             in_mon,
  fct_out_if                            out_mon,
  output int                            fail_cnt_o,
  output int                            pending_o
);
  import fct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [PlaneW-1:0] plane_copy [NumPlanes];
  bit                inside_verdicts [$];
  int                mismatches;

  // Exact plane distances; a p-vertex per plane for boxes, -radius bound for spheres
  function automatic bit predict_inside(
    input logic [CmdW-1:0]          cmd,
    input logic signed [CoordW-1:0] lo_x, lo_y, lo_z,
    input logic signed [CoordW-1:0] hi_x, hi_y, hi_z,
    input logic [RadiusW-1:0]       radius
  );
    logic signed [CoefW-1:0]    a, b, c;
    logic signed [DistOffW-1:0] d;
    longint                     x, y, z, dist_val, bound, r;
    if (cmd != CmdPoint && cmd != CmdSphere && cmd != CmdBox) return 1'b1;
    r = radius;
    bound = (cmd == CmdSphere) ? -(r <<< AlignShift) : 0;
    foreach (plane_copy[i]) begin
      a = plane_copy[i][ALo +: CoefW];
      b = plane_copy[i][BLo +: CoefW];
      c = plane_copy[i][CLo +: CoefW];
      d = plane_copy[i][DLo +: DistOffW];
      // box takes the max corner where the normal component is positive
      x = (cmd == CmdBox && a > 0) ? hi_x : lo_x;
      y = (cmd == CmdBox && b > 0) ? hi_y : lo_y;
      z = (cmd == CmdBox && c > 0) ? hi_z : lo_z;
      dist_val = x * a + y * b + z * c + (longint'(d) <<< AlignShift);
      if (dist_val < bound) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Plane copy, expected verdicts and comparison, all sampled at the edge
  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      plane_copy <= '{default: '0};
      inside_verdicts.delete();
      mismatches = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < NumPlanes) plane_copy[cfg_idx_i] <= cfg_data_i;

      // result transfer: compare with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (inside_verdicts.size() == 0) begin
          $error("inside_res: no result expected, got %0b", out_mon.inside_res);
          mismatches++;
        end else begin
          want = inside_verdicts.pop_front();
          if (out_mon.inside_res !== want) begin
            $error("inside_res: expected %0b, actual %0b", want, out_mon.inside_res);
            mismatches++;
          end
        end
      end

      // input transfer: predict with the planes in force before this edge
      if (in_mon.valid && in_mon.ready) begin
        inside_verdicts.push_back(predict_inside(in_mon.command,
                                                 in_mon.pos_x, in_mon.pos_y, in_mon.pos_z,
                                                 in_mon.max_x, in_mon.max_y, in_mon.max_z,
                                                 in_mon.radius));
      end

      fail_cnt_o <= mismatches;
      pending_o  <= inside_verdicts.size();
    end
  end

endmodule : fct_cull_checker

// File: test/tb_frustum_cull_test_top.sv
// ----------------------------------------------------------------------------
// tb_frustum_cull_test_top: stimulus and verdict for the frustum cull test
// Loads plane sets while the pipeline is empty, streams points, spheres,
// boxes and the unused command through the input channel with random gaps
// and random result stalls, and reports whether the checker counted failures.
// ----------------------------------------------------------------------------
module tb_frustum_cull_test_top;
  import fct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CmdW-1:0]      CmdUnused = 2'd3;
  localparam logic [PlaneIdxW-1:0] IdxSpareA = 3'd6;
  localparam logic [PlaneIdxW-1:0] IdxSpareB = 3'd7;
  localparam int UnitQ      = 256;          // 1.0 in Q16.8 and Q20.8
  localparam int OneQ10     = 1024;         // 1.0 in Q1.10
  localparam int CoordMax   = 2**23 - 1;
  localparam int CoordMin   = -(2**23);
  localparam int RadiusMax  = 2**23 - 1;
  localparam int DistMax    = 2**27 - 1;
  localparam int DistMin    = -(2**27);
  localparam int SettleCycles = 20;         // more than the pipeline depth
  localparam int TimeoutNs  = 500_000;
  localparam int RandPhases = 8;
  localparam int PhaseItems = 230;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic signed [CoordW-1:0] pos_x, pos_y, pos_z;
    logic signed [CoordW-1:0] max_x, max_y, max_z;
    logic [RadiusW-1:0]       radius;
  } prim_t;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [PlaneIdxW-1:0] cfg_idx;
  logic [PlaneW-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;
  bit                   steady_flow;

  fct_in_if  in_if ();
  fct_out_if out_if ();

  frustum_cull_test_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  fct_cull_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_count),
    .pending_o  (pending)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [PlaneW-1:0] pack_plane(input int a, input int b, input int c,
                                                   input int d);
    return {DistOffW'(d), CoefW'(c), CoefW'(b), CoefW'(a)};
  endfunction

  // random normal, offset mostly positive so a fair share of primitives pass
  function automatic logic [PlaneW-1:0] random_plane(input int scale);
    int coef [3];
    int offset;
    for (int k = 0; k < 3; k++)
      coef[k] = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 4095)) - 2048;
    offset = int'($urandom_range(0, 2**(scale + 4))) - 2**scale;
    return pack_plane(coef[0], coef[1], coef[2], offset);
  endfunction

  function automatic logic signed [CoordW-1:0] random_coord(input int scale);
    if ($urandom_range(0, 4) == 0) return CoordW'($urandom);
    return CoordW'(int'($urandom_range(0, 2**(scale + 1))) - 2**scale);
  endfunction

  function automatic prim_t random_prim(input int scale);
    prim_t p;
    int    pick;
    pick = $urandom_range(0, 19);
    p.command = (pick == 0) ? CmdUnused : (pick < 7) ? CmdPoint :
                (pick < 13) ? CmdSphere : CmdBox;
    p.pos_x = random_coord(scale);
    p.pos_y = random_coord(scale);
    p.pos_z = random_coord(scale);
    // boxes usually well ordered, sometimes with corners in any order
    if ($urandom_range(0, 7) == 0) begin
      p.max_x = random_coord(scale);
      p.max_y = random_coord(scale);
      p.max_z = random_coord(scale);
    end else begin
      p.max_x = p.pos_x + CoordW'($urandom_range(0, 2**scale));
      p.max_y = p.pos_y + CoordW'($urandom_range(0, 2**scale));
      p.max_z = p.pos_z + CoordW'($urandom_range(0, 2**scale));
    end
    p.radius = ($urandom_range(0, 4) == 0) ? RadiusW'($urandom) :
                                             RadiusW'($urandom_range(0, 2**scale));
    return p;
  endfunction

  function automatic prim_t make_prim(input logic [CmdW-1:0] cmd, input int x, input int y,
                                      input int z, input int mx, input int my, input int mz,
                                      input int r);
    prim_t p;
    p.command = cmd;
    p.pos_x = CoordW'(x);
    p.pos_y = CoordW'(y);
    p.pos_z = CoordW'(z);
    p.max_x = CoordW'(mx);
    p.max_y = CoordW'(my);
    p.max_z = CoordW'(mz);
    p.radius = RadiusW'(r);
    return p;
  endfunction

  // one input transfer after a random gap
  task automatic send_prim(input prim_t p);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= p.command;
    in_if.pos_x   <= p.pos_x;
    in_if.pos_y   <= p.pos_y;
    in_if.pos_z   <= p.pos_z;
    in_if.max_x   <= p.max_x;
    in_if.max_y   <= p.max_y;
    in_if.max_z   <= p.max_z;
    in_if.radius  <= p.radius;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // write all six planes, optionally followed by writes to the unused indexes
  task automatic load_planes(input logic [PlaneW-1:0] planes [NumPlanes],
                             input bit spare_writes);
    for (int k = 0; k < NumPlanes; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= PlaneIdxW'(k);
      cfg_data <= planes[k];
      @(posedge clk_i);
    end
    if (spare_writes) begin
      cfg_idx  <= IdxSpareA;
      cfg_data <= {$urandom, $urandom};
      @(posedge clk_i);
      cfg_idx  <= IdxSpareB;
      cfg_data <= '1;
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // stop sending and wait until every verdict is back and the pipe is empty
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // result side: random stall before each result
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  // main stimulus
  initial begin
    logic [PlaneW-1:0] frustum [NumPlanes];
    int                scale;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.command <= CmdPoint;
    in_if.pos_x   <= '0;
    in_if.pos_y   <= '0;
    in_if.pos_z   <= '0;
    in_if.max_x   <= '0;
    in_if.max_y   <= '0;
    in_if.max_z   <= '0;
    in_if.radius  <= '0;
    steady_flow = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset planes: everything reads inside
    send_prim(make_prim(CmdPoint, CoordMin, CoordMin, CoordMin, 0, 0, 0, 0));
    send_prim(make_prim(CmdBox, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin, 0));
    send_prim(make_prim(CmdSphere, CoordMax, CoordMin, CoordMax, 0, 0, 0, RadiusMax));
    drain();

    // axis-aligned cube of +-100 units; zero normal components on every plane
    frustum[0] = pack_plane(OneQ10, 0, 0, 100 * UnitQ);
    frustum[1] = pack_plane(-OneQ10, 0, 0, 100 * UnitQ);
    frustum[2] = pack_plane(0, -OneQ10, 0, 100 * UnitQ);
    frustum[3] = pack_plane(0, OneQ10, 0, 100 * UnitQ);
    frustum[4] = pack_plane(0, 0, OneQ10, 100 * UnitQ);
    frustum[5] = pack_plane(0, 0, -OneQ10, 100 * UnitQ);
    load_planes(frustum, 1'b0);
    send_prim(make_prim(CmdPoint, 0, 0, 0, 0, 0, 0, 0));
    send_prim(make_prim(CmdPoint, 100 * UnitQ, -100 * UnitQ, 100 * UnitQ, 0, 0, 0, 0));
    send_prim(make_prim(CmdPoint, 100 * UnitQ + 1, 0, 0, 0, 0, 0, 0));
    send_prim(make_prim(CmdPoint, 0, -100 * UnitQ - 1, 0, 0, 0, 0, 0));
    send_prim(make_prim(CmdPoint, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                        RadiusMax));
    send_prim(make_prim(CmdPoint, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, 0));
    // sphere touching a plane exactly, then one just short of it
    send_prim(make_prim(CmdSphere, 150 * UnitQ, 0, 0, 0, 0, 0, 50 * UnitQ));
    send_prim(make_prim(CmdSphere, 150 * UnitQ, 0, 0, 0, 0, 0, 50 * UnitQ - 1));
    send_prim(make_prim(CmdSphere, CoordMin, CoordMin, CoordMin, 0, 0, 0, RadiusMax));
    send_prim(make_prim(CmdSphere, 0, 0, 0, 0, 0, 0, 0));
    send_prim(make_prim(CmdBox, CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax, 0));
    send_prim(make_prim(CmdBox, 200 * UnitQ, 0, 0, 300 * UnitQ, 0, 0, 0));
    send_prim(make_prim(CmdBox, 50 * UnitQ, 0, 0, 150 * UnitQ, 0, 0, 0));
    // box with its minimum above its maximum
    send_prim(make_prim(CmdBox, 150 * UnitQ, 0, 0, -150 * UnitQ, 0, 0, 0));
    // unused command never culls
    send_prim(make_prim(CmdUnused, 500 * UnitQ, 0, 0, 0, 0, 0, 0));
    send_prim(make_prim(CmdUnused, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, CoordMin,
                        RadiusMax));
    drain();

    // extreme plane sets: huge positive offset, huge negative, all ones, all zeros
    for (int e = 0; e < 4; e++) begin
      for (int k = 0; k < NumPlanes; k++) begin
        case (e)
          0: frustum[k] = pack_plane(k[0] ? -2048 : 2047, k[0] ? 2047 : -2048,
                                     k[1] ? 0 : 2047, DistMax);
          1: frustum[k] = pack_plane(k[0] ? 2047 : -2048, k[1] ? -2048 : 2047,
                                     k[0] ? 0 : -2048, DistMin);
          2: frustum[k] = '1;
          default: frustum[k] = '0;
        endcase
      end
      load_planes(frustum, 1'b0);
      for (int n = 0; n < 15; n++) send_prim(random_prim(22));
      drain();
    end

    // random plane sets at growing coordinate scales
    for (int ph = 0; ph < RandPhases; ph++) begin
      scale = 6 + 2 * ph;
      for (int k = 0; k < NumPlanes; k++)
        frustum[k] = (ph == 3) ? {$urandom, $urandom} : random_plane(scale);
      load_planes(frustum, ph == 5);
      for (int n = 0; n < PhaseItems; n++) begin
        // some stretches run without any idling on either side
        if (n % 50 == 0) steady_flow = ($urandom_range(0, 2) == 0);
        send_prim(random_prim(scale));
      end
      steady_flow = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TimeoutNs);
    $display("Test completed with failures");
    $finish;
  end

endmodule : tb_frustum_cull_test_top

// File: files.f
src/fct_pkg.sv
src/fct_in_if.sv
src/fct_out_if.sv
src/fct_cell.sv
src/frustum_cull_test_top.sv
test/fct_cull_checker.sv
test/tb_frustum_cull_test_top.sv
